// ===== hw/rtl/two_class_priority_fifo_core_assert.svh =====
// Assertion macros shared by the two-class priority FIFO modules.
`ifndef TWO_CLASS_PRIORITY_FIFO_CORE_ASSERT_SVH
`define TWO_CLASS_PRIORITY_FIFO_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define TCPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tcpf assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define TCPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tcpf assertion failed");
`else
`define TCPF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TCPF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/tcpf_pkg.sv =====
// Types and constants of the two-class priority FIFO.
package tcpf_pkg;

  localparam int DATA_BITS     = 32;
  localparam int TIME_BITS     = 32;
  localparam int SUM_BITS      = 64;
  localparam int TALLY_BITS    = 32;
  localparam int CAP_BITS      = 5;
  localparam int CAP_RESET     = 16;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic REQ_PUT = 1'b0;
  localparam logic REQ_GET = 1'b1;

  typedef enum logic [1:0] {
    STAT_PUT_OK    = 2'd0,
    STAT_GET_OK    = 2'd1,
    STAT_PUT_FULL  = 2'd2,
    STAT_GET_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_FETCH = 1'b1
  } state_t;

  typedef struct packed {
    logic                 req_type;
    logic [DATA_BITS-1:0] item_data;
    logic                 item_urgent;
    logic                 item_poison;
    logic [TIME_BITS-1:0] time_now;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [DATA_BITS-1:0]  out_data;
    logic                  out_urgent;
    logic                  out_poison;
    logic [TIME_BITS-1:0]  item_latency;
    logic [SUM_BITS-1:0]   latency_total;
    logic [TALLY_BITS-1:0] latency_count;
    logic [TALLY_BITS-1:0] real_seen;
    logic [TIME_BITS-1:0]  first_put_time;
    logic                  first_put_valid;
    logic [TIME_BITS-1:0]  last_get_time;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;  // input beat taken this cycle
    logic fetch;   // store read data is valid, finish the get
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;   // both queues empty
  } dp_stat_t;

endpackage

// ===== hw/rtl/tcpf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module tcpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/tcpf_ctrl.sv =====
// Controller state machine of the two-class priority FIFO.
`include "two_class_priority_fifo_core_assert.svh"
module tcpf_ctrl
  import tcpf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_req_get,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   go_fetch;
  logic   load_out;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (go_fetch) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.fetch  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // Result register is free now or drains on this edge.
        in_ready   = !out_valid_r || out_ready;
        cmd.accept = in_valid && in_ready;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign go_fetch = cmd.accept && (in_req_get == REQ_GET) && !stat.empty;
  // Puts and empty gets finish at accept; a delivering get in the cycle after, in fetch.
  assign load_out = (cmd.accept && !go_fetch) || cmd.fetch;

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `TCPF_ASSERT_NOW(a_fetch_slot_free, clk, rst_n, state_r == S_FETCH, !out_valid_r)
  `TCPF_ASSERT_NEXT(a_fetch_one_cycle, clk, rst_n, state_r == S_FETCH, state_r == S_IDLE)
  `TCPF_ASSERT_NEXT(a_get_goes_fetch, clk, rst_n, go_fetch, (state_r == S_FETCH) && !in_ready)

endmodule

// ===== hw/rtl/tcpf_datapath.sv =====
// Datapath of the two-class priority FIFO: pointers, counts, stores, statistics.
`include "two_class_priority_fifo_core_assert.svh"
module tcpf_datapath
  import tcpf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CAP_BITS-1:0] cfg_data,
  input  in_item_t            in_item,
  input  cmd_t                cmd,
  output dp_stat_t            stat,
  output out_item_t           out_item
);

  localparam int PTR_W  = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int TOT_W  = FILL_W + 1;
  localparam int U_W    = TIME_BITS + DATA_BITS;
  localparam int N_W    = 2 + TIME_BITS + DATA_BITS;

  logic [CAP_BITS-1:0]   cap_r;
  logic [PTR_W-1:0]      u_wp_r, u_wp_nxt, u_rp_r, u_rp_nxt;
  logic [PTR_W-1:0]      n_wp_r, n_wp_nxt, n_rp_r, n_rp_nxt;
  logic [FILL_W-1:0]     u_fill_r, u_fill_nxt, n_fill_r, n_fill_nxt;
  logic [SUM_BITS-1:0]   sum_r, sum_nxt;
  logic [TALLY_BITS-1:0] samp_r, samp_nxt, real_r, real_nxt;
  logic [TIME_BITS-1:0]  first_r, first_nxt, last_r, last_nxt;
  logic                  first_seen_r, first_seen_nxt;
  logic                  sel_urg_r, sel_urg_nxt;
  logic [TIME_BITS-1:0]  time_r, time_nxt;
  out_item_t             out_r, out_nxt;

  logic [FILL_W-1:0]     limit;
  logic [TOT_W-1:0]      total;
  logic                  is_get, is_put, full, empty;
  logic                  u_we, n_we;
  logic [U_W-1:0]        u_rdata;
  logic [N_W-1:0]        n_rdata;
  logic [DATA_BITS-1:0]  f_data;
  logic [TIME_BITS-1:0]  f_stamp, f_lat;
  logic                  f_urg, f_poi;
  logic [SUM_BITS:0]     sum_add;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [FILL_W-1:0] lim);
    logic [FILL_W:0] nx;
    nx = (FILL_W + 1)'(p) + 1'b1;
    return (nx >= (FILL_W + 1)'(lim)) ? '0 : PTR_W'(nx);
  endfunction

  // Capacity above the store depth acts as the depth.
  assign limit = (32'(cap_r) > 32'(DEPTH)) ? FILL_W'(DEPTH) : FILL_W'(cap_r);
  assign total = TOT_W'(u_fill_r) + TOT_W'(n_fill_r);
  assign full  = total >= TOT_W'(limit);
  assign empty = total == '0;
  assign stat.empty = empty;

  assign is_put = cmd.accept && (in_item.req_type == REQ_PUT);
  assign is_get = cmd.accept && (in_item.req_type == REQ_GET);
  assign u_we   = is_put && !full && !in_item.item_poison && in_item.item_urgent;
  assign n_we   = is_put && !full && !(!in_item.item_poison && in_item.item_urgent);

  tcpf_ram #(.WIDTH(U_W), .DEPTH(DEPTH)) u_urgent_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_wp_r),
    .wdata ({in_item.time_now, in_item.item_data}),
    .re    (is_get),
    .raddr (u_rp_r),
    .rdata (u_rdata)
  );

  tcpf_ram #(.WIDTH(N_W), .DEPTH(DEPTH)) u_normal_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_wp_r),
    .wdata ({in_item.item_poison, in_item.item_urgent, in_item.time_now, in_item.item_data}),
    .re    (is_get),
    .raddr (n_rp_r),
    .rdata (n_rdata)
  );

  // Fields of the fetched entry.
  always_comb begin
    if (sel_urg_r) begin
      f_data  = u_rdata[DATA_BITS-1:0];
      f_stamp = u_rdata[U_W-1:DATA_BITS];
      f_urg   = 1'b1;
      f_poi   = 1'b0;
    end else begin
      f_data  = n_rdata[DATA_BITS-1:0];
      f_stamp = n_rdata[DATA_BITS+TIME_BITS-1:DATA_BITS];
      f_urg   = n_rdata[N_W-2];
      f_poi   = n_rdata[N_W-1];
    end
  end

  assign f_lat   = (time_r >= f_stamp) ? (time_r - f_stamp) : '0;
  assign sum_add = {1'b0, sum_r} + (SUM_BITS + 1)'(f_lat);

  always_comb begin
    u_wp_nxt       = u_wp_r;
    u_rp_nxt       = u_rp_r;
    n_wp_nxt       = n_wp_r;
    n_rp_nxt       = n_rp_r;
    u_fill_nxt     = u_fill_r;
    n_fill_nxt     = n_fill_r;
    sum_nxt        = sum_r;
    samp_nxt       = samp_r;
    real_nxt       = real_r;
    first_nxt      = first_r;
    first_seen_nxt = first_seen_r;
    last_nxt       = last_r;
    sel_urg_nxt    = sel_urg_r;
    time_nxt       = time_r;
    out_nxt        = out_r;

    if (is_put && !full) begin
      if (!in_item.item_poison && !first_seen_r) begin
        first_nxt      = in_item.time_now;
        first_seen_nxt = 1'b1;
      end
      if (u_we) begin
        u_wp_nxt   = advance(u_wp_r, limit);
        u_fill_nxt = u_fill_r + 1'b1;
      end else begin
        n_wp_nxt   = advance(n_wp_r, limit);
        n_fill_nxt = n_fill_r + 1'b1;
      end
    end

    if (is_get && !empty) begin
      sel_urg_nxt = u_fill_r != '0;
      time_nxt    = in_item.time_now;
      if (u_fill_r != '0) begin
        u_rp_nxt   = advance(u_rp_r, limit);
        u_fill_nxt = u_fill_r - 1'b1;
      end else begin
        n_rp_nxt   = advance(n_rp_r, limit);
        n_fill_nxt = n_fill_r - 1'b1;
      end
    end

    if (cmd.fetch && !f_poi) begin
      real_nxt = real_r + 1'b1;
      samp_nxt = samp_r + 1'b1;
      sum_nxt  = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
      last_nxt = time_r;
    end

    // Result beat: puts and empty gets now, delivering gets after the fetch.
    if ((cmd.accept && !(is_get && !empty)) || cmd.fetch) begin
      out_nxt.out_data     = '0;
      out_nxt.out_urgent   = 1'b0;
      out_nxt.out_poison   = 1'b0;
      out_nxt.item_latency = '0;
      if (cmd.fetch) begin
        out_nxt.status       = STAT_GET_OK;
        out_nxt.out_data     = f_data;
        out_nxt.out_urgent   = f_urg;
        out_nxt.out_poison   = f_poi;
        out_nxt.item_latency = f_poi ? '0 : f_lat;
      end else if (is_put) begin
        out_nxt.status = full ? STAT_PUT_FULL : STAT_PUT_OK;
      end else begin
        out_nxt.status = STAT_GET_EMPTY;
      end
      out_nxt.latency_total   = sum_nxt;
      out_nxt.latency_count   = samp_nxt;
      out_nxt.real_seen       = real_nxt;
      out_nxt.first_put_time  = first_nxt;
      out_nxt.first_put_valid = first_seen_nxt;
      out_nxt.last_get_time   = last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CAP_BITS'(CAP_RESET);
      u_wp_r       <= '0;
      u_rp_r       <= '0;
      n_wp_r       <= '0;
      n_rp_r       <= '0;
      u_fill_r     <= '0;
      n_fill_r     <= '0;
      sum_r        <= '0;
      samp_r       <= '0;
      real_r       <= '0;
      first_r      <= '0;
      first_seen_r <= 1'b0;
      last_r       <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      u_wp_r       <= u_wp_nxt;
      u_rp_r       <= u_rp_nxt;
      n_wp_r       <= n_wp_nxt;
      n_rp_r       <= n_rp_nxt;
      u_fill_r     <= u_fill_nxt;
      n_fill_r     <= n_fill_nxt;
      sum_r        <= sum_nxt;
      samp_r       <= samp_nxt;
      real_r       <= real_nxt;
      first_r      <= first_nxt;
      first_seen_r <= first_seen_nxt;
      last_r       <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_urg_r <= sel_urg_nxt;
    time_r    <= time_nxt;
    out_r     <= out_nxt;
  end

  assign out_item = out_r;

  `TCPF_ASSERT_NOW(a_total_bounded, clk, rst_n, 1'b1, 32'(total) <= 32'(DEPTH))

endmodule

// ===== hw/rtl/two_class_priority_fifo_core.sv =====
// Top level of the two-class priority FIFO core.
// Two-class priority FIFO: one request channel carries put and get beats, one
// result channel returns exactly one result beat per request. Non-poison urgent
// puts go to the urgent queue, all other puts to the normal queue; both share
// the capacity limit written on the cfg port (reset 16, values above DEPTH act
// as DEPTH, zero rejects every put). A get serves the urgent queue first and
// reports the latency against the time stamp saved at the put, plus running
// statistics. A put, a rejected put and a get from an empty buffer finish in the
// accept cycle; a get that delivers also passes through the fetch state, for the
// registered read of the item store, and no request is taken there.
// The result register lets a new request enter while the last result beat is
// being taken in the same cycle. The item stores have no reset and need no
// clearing pass. Capacity writes are taken at any time, one per cycle, but are
// meant to land only while no request is in flight.
module two_class_priority_fifo_core
  import tcpf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CAP_BITS-1:0] cfg_data
);

  cmd_t     cmd;
  dp_stat_t stat;

  // Capacity register always takes its beat.
  assign cfg_ready = 1'b1;

  tcpf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req_get (in_item.req_type),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tcpf_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

// ===== test/priority_fifo_check.sv =====
// Watches the request, result and capacity channels, predicts each result and compares it.
module priority_fifo_check
  import tcpf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CAP_BITS-1:0] cfg_data,
  output int                  fails,
  output int                  replies_pending
);

  localparam int SLOTS = DEPTH_DEFAULT;

  // Shadow copy of the two queues and the statistics.
  logic [CAP_BITS-1:0]   cap_reg;
  logic [DATA_BITS-1:0]  urg_data  [SLOTS];
  logic [TIME_BITS-1:0]  urg_stamp [SLOTS];
  logic [DATA_BITS-1:0]  nrm_data  [SLOTS];
  logic [TIME_BITS-1:0]  nrm_stamp [SLOTS];
  logic [1:0]            nrm_flags [SLOTS];  // {poison, urgent}
  int                    urg_wr, urg_rd, urg_fill;
  int                    nrm_wr, nrm_rd, nrm_fill;
  logic [SUM_BITS-1:0]   lat_sum;
  logic [TALLY_BITS-1:0] sample_cnt, real_cnt;
  logic [TIME_BITS-1:0]  first_time, last_time;
  logic                  first_seen;

  out_item_t replies_due [$];
  int        fail_tally = 0;
  int        due_count  = 0;

  assign fails           = fail_tally;
  assign replies_pending = due_count;

  function automatic int slot_limit();
    return (cap_reg > SLOTS) ? SLOTS : int'(cap_reg);
  endfunction

  // Pointers wrap at the current limit, not at the store depth.
  function automatic int next_slot(int ptr);
    return (ptr + 1 >= slot_limit()) ? 0 : ptr + 1;
  endfunction

  function automatic out_item_t fifo_reply(in_item_t req);
    out_item_t            r;
    logic [TIME_BITS-1:0] stamp;
    logic [SUM_BITS:0]    wide;
    r     = '0;
    stamp = '0;
    if (req.req_type == REQ_PUT) begin
      if (urg_fill + nrm_fill >= slot_limit()) begin
        r.status = STAT_PUT_FULL;
      end else begin
        r.status = STAT_PUT_OK;
        if (!req.item_poison && !first_seen) begin
          first_time = req.time_now;
          first_seen = 1'b1;
        end
        if (!req.item_poison && req.item_urgent) begin
          urg_data[urg_wr]  = req.item_data;
          urg_stamp[urg_wr] = req.time_now;
          urg_wr            = next_slot(urg_wr);
          urg_fill++;
        end else begin
          nrm_data[nrm_wr]  = req.item_data;
          nrm_stamp[nrm_wr] = req.time_now;
          nrm_flags[nrm_wr] = {req.item_poison, req.item_urgent};
          nrm_wr            = next_slot(nrm_wr);
          nrm_fill++;
        end
      end
    end else if (urg_fill + nrm_fill == 0) begin
      r.status = STAT_GET_EMPTY;
    end else begin
      r.status = STAT_GET_OK;
      if (urg_fill > 0) begin
        r.out_data   = urg_data[urg_rd];
        stamp        = urg_stamp[urg_rd];
        r.out_urgent = 1'b1;
        urg_rd       = next_slot(urg_rd);
        urg_fill--;
      end else begin
        r.out_data   = nrm_data[nrm_rd];
        stamp        = nrm_stamp[nrm_rd];
        r.out_urgent = nrm_flags[nrm_rd][0];
        r.out_poison = nrm_flags[nrm_rd][1];
        nrm_rd       = next_slot(nrm_rd);
        nrm_fill--;
      end
      // Poison markers leave every statistic alone.
      if (!r.out_poison) begin
        real_cnt++;
        r.item_latency = (req.time_now >= stamp) ? req.time_now - stamp : '0;
        wide           = {1'b0, lat_sum} + (SUM_BITS + 1)'(r.item_latency);
        lat_sum        = wide[SUM_BITS] ? '1 : wide[SUM_BITS-1:0];
        sample_cnt++;
        last_time = req.time_now;
      end
    end
    r.latency_total   = lat_sum;
    r.latency_count   = sample_cnt;
    r.real_seen       = real_cnt;
    r.first_put_time  = first_time;
    r.first_put_valid = first_seen;
    r.last_get_time   = last_time;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_tally++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      cap_reg    = CAP_BITS'(CAP_RESET);
      urg_wr     = 0;
      urg_rd     = 0;
      urg_fill   = 0;
      nrm_wr     = 0;
      nrm_rd     = 0;
      nrm_fill   = 0;
      lat_sum    = '0;
      sample_cnt = '0;
      real_cnt   = '0;
      first_time = '0;
      last_time  = '0;
      first_seen = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        urg_data[i]  = '0;
        urg_stamp[i] = '0;
        nrm_data[i]  = '0;
        nrm_stamp[i] = '0;
        nrm_flags[i] = '0;
      end
      replies_due.delete();
    end else begin
      // Retire first: a result never belongs to a request taken at the same edge.
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("result beat with no request outstanding");
          fail_tally++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", want.status, out_item.status);
          check_field("out_data", want.out_data, out_item.out_data);
          check_field("out_urgent", want.out_urgent, out_item.out_urgent);
          check_field("out_poison", want.out_poison, out_item.out_poison);
          check_field("item_latency", want.item_latency, out_item.item_latency);
          check_field("latency_total", want.latency_total, out_item.latency_total);
          check_field("latency_count", want.latency_count, out_item.latency_count);
          check_field("real_seen", want.real_seen, out_item.real_seen);
          check_field("first_put_time", want.first_put_time, out_item.first_put_time);
          check_field("first_put_valid", want.first_put_valid, out_item.first_put_valid);
          check_field("last_get_time", want.last_get_time, out_item.last_get_time);
        end
      end
      if (cfg_valid && cfg_ready) cap_reg = cfg_data;
      if (in_valid && in_ready) replies_due.push_back(fifo_reply(in_item));
    end
    due_count = replies_due.size();
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for the two-class priority FIFO core: stimulus, handshake idling and verdict.
module tb;
  import tcpf_pkg::*;

  // Even with heavy idling on both sides, about a thousand beats fit many times
  // over in this budget.
  localparam int CYCLE_LIMIT = 400000;
  localparam int BEATS_PER_SETTING = 68;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  in_item_t            in_item   = '0;
  logic                out_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CAP_BITS-1:0] cfg_data  = '0;
  logic                in_ready;
  logic                out_valid;
  logic                cfg_ready;
  out_item_t           out_item;

  int fails;
  int replies_pending;
  int cycles       = 0;
  int beats_sent   = 0;
  int cap_writes   = 0;
  int send_gap_pct = 0;   // chance per cycle that the sender holds off
  int recv_gap_pct = 0;   // chance per cycle that the receiver stalls

  // Running time base: mostly monotonic, with occasional jumps and extremes.
  logic [TIME_BITS-1:0] tick = '0;

  always #5 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  // Receiver backpressure, redrawn every cycle.
  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);

  two_class_priority_fifo_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  priority_fifo_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fails           (fails),
    .replies_pending (replies_pending)
  );

  // Mostly small steps forward; a few random jumps (time may go backwards,
  // which gives the clamped-latency case) and a few hits on 0 and all ones.
  function automatic logic [TIME_BITS-1:0] next_time();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      tick = $urandom;
      return tick;
    end
    if (pick < 6) return (pick == 4) ? '0 : '1;
    tick = tick + $urandom_range(0, 40);
    return tick;
  endfunction

  function automatic in_item_t put_req(logic [DATA_BITS-1:0] data, logic urg, logic poi,
                                       logic [TIME_BITS-1:0] t);
    in_item_t r;
    r.req_type    = REQ_PUT;
    r.item_data   = data;
    r.item_urgent = urg;
    r.item_poison = poi;
    r.time_now    = t;
    return r;
  endfunction

  // Payload and flags are don't-care on a get; fill them with junk anyway.
  function automatic in_item_t get_req(logic [TIME_BITS-1:0] t);
    in_item_t r;
    r.req_type    = REQ_GET;
    r.item_data   = $urandom;
    r.item_urgent = 1'($urandom_range(0, 1));
    r.item_poison = 1'($urandom_range(0, 1));
    r.time_now    = t;
    return r;
  endfunction

  function automatic in_item_t random_req(int put_pct);
    logic [DATA_BITS-1:0] data;
    if ($urandom_range(0, 99) >= put_pct) return get_req(next_time());
    case ($urandom_range(0, 19))
      0:       data = '0;
      1:       data = '1;
      default: data = $urandom;
    endcase
    return put_req(data, $urandom_range(0, 99) < 40, $urandom_range(0, 99) < 15, next_time());
  endfunction

  // Called right after a falling edge; returns right after the falling edge
  // that follows the accepting rising edge. Valid stays up between back-to-back
  // beats, so it is only lowered when a gap is actually taken.
  task automatic push_beat(input in_item_t beat);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= beat;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    beats_sent++;
  endtask

  // Hold the sender until every outstanding result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (replies_pending != 0) @(negedge clk);
  endtask

  // Capacity writes land only with nothing in flight; items may still be held.
  task automatic write_capacity(input logic [CAP_BITS-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Run stopped at cycle limit %0d", CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [CAP_BITS-1:0] caps [12];
    caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd17, 5'd2, 5'd16, 5'd12, 5'd30, 5'd5, 5'd16};

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---------------- directed part, no idling ----------------
    push_beat(get_req(next_time()));  // get from empty buffer

    // Fill the urgent queue to the full limit, bounce one put, drain it.
    // This also writes every urgent store slot, so later capacity changes
    // with items held can never read a slot that was never written.
    for (int i = 0; i < 16; i++)
      push_beat(put_req((i == 0) ? '0 : ((i == 15) ? '1 : $urandom), 1'b1, 1'b0, next_time()));
    push_beat(put_req($urandom, 1'b0, 1'b1, next_time()));   // rejected full
    for (int i = 0; i < 16; i++) push_beat(get_req(next_time()));

    // Fill again, walking all urgent/poison flag pairs over both queues:
    // poison marked urgent still goes to the normal queue.
    for (int i = 0; i < 16; i++) push_beat(put_req($urandom, i[0], i[1], next_time()));
    for (int i = 0; i < 16; i++) push_beat(get_req(next_time()));
    push_beat(get_req(next_time()));

    // Get earlier than put: latency clamps to zero. Then the widest latency.
    push_beat(put_req($urandom, 1'b0, 1'b0, '1));
    push_beat(get_req('0));
    push_beat(put_req($urandom, 1'b1, 1'b0, '0));
    push_beat(get_req('1));

    // Urgent overtakes a normal item put before it.
    push_beat(put_req($urandom, 1'b0, 1'b0, next_time()));
    push_beat(put_req($urandom, 1'b1, 1'b0, next_time()));
    push_beat(get_req(next_time()));
    push_beat(get_req(next_time()));

    // Zero capacity: puts bounce but held items still drain.
    push_beat(put_req($urandom, 1'b0, 1'b0, next_time()));
    push_beat(put_req($urandom, 1'b1, 1'b0, next_time()));
    write_capacity(5'd0);
    push_beat(put_req($urandom, 1'b0, 1'b0, next_time()));
    push_beat(get_req(next_time()));
    push_beat(get_req(next_time()));
    push_beat(get_req(next_time()));

    // Capacity above the depth acts as the depth; capacity one.
    write_capacity(5'd31);
    for (int i = 0; i < 17; i++) push_beat(put_req($urandom, 1'b0, 1'b0, next_time()));
    write_capacity(5'd1);
    push_beat(put_req($urandom, 1'b1, 1'b0, next_time()));  // still over limit
    for (int i = 0; i < 16; i++) push_beat(get_req(next_time()));
    push_beat(put_req($urandom, 1'b1, 1'b0, next_time()));
    push_beat(put_req($urandom, 1'b0, 1'b0, next_time()));  // full at one
    push_beat(get_req(next_time()));

    // Limit lowered below the held count: puts bounce until it drains.
    write_capacity(5'd16);
    for (int i = 0; i < 6; i++) push_beat(put_req($urandom, 1'b0, i[0], next_time()));
    write_capacity(5'd3);
    push_beat(put_req($urandom, 1'b0, 1'b0, next_time()));
    for (int i = 0; i < 7; i++) push_beat(get_req(next_time()));

    // ---------------- random part ----------------
    // Three handshake phases: sender idles lightly while the receiver stalls
    // hard, then the reverse, then full throughput. Each phase walks four
    // capacity settings, alternating put-heavy and get-heavy traffic so the
    // buffer keeps hitting both full and empty.
    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = (ph == 0) ? 29 : ((ph == 1) ? 86 : 0);
      recv_gap_pct = (ph == 0) ? 86 : ((ph == 1) ? 29 : 0);
      for (int sub = 0; sub < 4; sub++) begin
        write_capacity((sub == 3) ? 5'($urandom_range(0, 31)) : caps[ph * 4 + sub]);
        for (int n = 0; n < BEATS_PER_SETTING; n++) begin
          // Now and then let everything settle before going on.
          if ($urandom_range(0, 79) == 0) drain();
          push_beat(random_req((sub % 2 == 0) ? 65 : 38));
        end
      end
    end

    // Wait out the last results, then let the clock run on for any stray beat.
    drain();
    repeat (10) @(negedge clk);

    $display("Covered %0d request beats and %0d capacity writes in %0d cycles,",
             beats_sent, cap_writes, cycles);
    $display("under light, heavy and no idling on both channels; %0d mismatches.", fails);
    if (fails == 0 && replies_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
